@@ sv/mrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP v1 response decoder package
// Beat types, register indexes, header bytes and frame status codes.
// ----------------------------------------------------------------------------
package mrd_pkg;

   localparam logic [7:0] HDR_START = 8'h24;  // '$'
   localparam logic [7:0] HDR_M     = 8'h4D;  // 'M'
   localparam logic [7:0] HDR_DIR   = 8'h3E;  // '>'

   localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'd108;
   localparam logic [7:0] STORE_LIMIT_RESET      = 8'd64;

   localparam logic [7:0] CSR_EXPECTED_COMMAND = 8'd0;
   localparam logic [7:0] CSR_STORE_LIMIT      = 8'd1;

   localparam logic ACTION_BYTE  = 1'b0;
   localparam logic ACTION_ABORT = 1'b1;

   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CHECKSUM  = 2'd1,
      STATUS_COMMAND   = 2'd2
   } status_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [1:0] frame_status;
      logic [7:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0] index;
      logic [7:0] data;
   } csr_type;

   typedef struct packed {
      logic [7:0] expected_command;
      logic [7:0] store_limit;
   } cfg_type;

endpackage

@@ sv/mrd_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP v1 response decoder stream channel
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface mrd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/mrd_csr_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP v1 response decoder control registers
// Holds expected command and store limit, written over the csr channel.
// ----------------------------------------------------------------------------
module mrd_csr_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  mrd_pkg::csr_type  wr_beat,
   output mrd_pkg::cfg_type  cfg
);

   mrd_pkg::cfg_type cfg_ff;
   mrd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         // unknown indexes are dropped
         if (wr_beat.index == mrd_pkg::CSR_EXPECTED_COMMAND) begin
            cfg_in.expected_command = wr_beat.data;
         end else if (wr_beat.index == mrd_pkg::CSR_STORE_LIMIT) begin
            cfg_in.store_limit = wr_beat.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command <= mrd_pkg::EXPECTED_COMMAND_RESET;
         cfg_ff.store_limit      <= mrd_pkg::STORE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/mrd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP v1 response decoder frame parser
// Header hunt, length/command capture, checksum and per-byte result build.
// ----------------------------------------------------------------------------
module mrd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  mrd_pkg::req_type  item,
   input  mrd_pkg::cfg_type  cfg,
   output logic              res_valid,
   output mrd_pkg::rsp_type  res
);

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_M    = 3'd1,
      PH_DIR  = 3'd2,
      PH_LEN  = 3'd3,
      PH_CMD  = 3'd4,
      PH_BODY = 3'd5
   } phase_type;

   phase_type  phase_ff,    phase_in;
   logic [7:0] length_ff,   length_in;
   logic [7:0] command_ff,  command_in;
   logic [7:0] checksum_ff, checksum_in;
   logic [7:0] count_ff,    count_in;

   logic [7:0] c;

   assign c = item.rx_byte;

   always_comb begin
      phase_in    = phase_ff;
      length_in   = length_ff;
      command_in  = command_ff;
      checksum_in = checksum_ff;
      count_in    = count_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (item.action == mrd_pkg::ACTION_ABORT) begin
         phase_in    = PH_HUNT;
         length_in   = '0;
         command_in  = '0;
         checksum_in = '0;
         count_in    = '0;
      end else begin
         unique case (phase_ff)
            PH_M: begin
               phase_in = (c == mrd_pkg::HDR_M) ? PH_DIR : PH_HUNT;
            end
            PH_DIR: begin
               phase_in = (c == mrd_pkg::HDR_DIR) ? PH_LEN : PH_HUNT;
            end
            PH_LEN: begin
               length_in   = c;
               checksum_in = checksum_ff ^ c;
               phase_in    = PH_CMD;
            end
            PH_CMD: begin
               command_in  = c;
               checksum_in = checksum_ff ^ c;
               phase_in    = PH_BODY;
            end
            PH_BODY: begin
               if (count_ff < length_ff) begin
                  checksum_in = checksum_ff ^ c;
                  count_in    = count_ff + 8'd1;
                  if (count_ff < cfg.store_limit) begin
                     res_valid         = 1'b1;
                     res.result_kind   = mrd_pkg::KIND_PAYLOAD;
                     res.payload_byte  = c;
                     res.payload_index = count_ff;
                  end
               end else begin
                  // checksum byte: report, then restart the hunt
                  res_valid        = 1'b1;
                  res.result_kind  = mrd_pkg::KIND_FRAME_END;
                  res.frame_length = length_ff;
                  if (command_ff != cfg.expected_command) begin
                     res.frame_status = mrd_pkg::STATUS_COMMAND;
                  end else if (checksum_ff != c) begin
                     res.frame_status = mrd_pkg::STATUS_CHECKSUM;
                  end else begin
                     res.frame_status = mrd_pkg::STATUS_OK;
                  end
                  phase_in    = PH_HUNT;
                  length_in   = '0;
                  command_in  = '0;
                  checksum_in = '0;
                  count_in    = '0;
               end
            end
            default: begin
               phase_in = (c == mrd_pkg::HDR_START) ? PH_M : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         length_ff   <= '0;
         command_ff  <= '0;
         checksum_ff <= '0;
         count_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         length_ff   <= length_in;
         command_ff  <= command_in;
         checksum_ff <= checksum_in;
         count_ff    <= count_in;
      end
   end

endmodule

@@ sv/msp_v1_response_decoder_top.sv @@
`timescale 1ns / 1ps
// Path: req byte -> input register -> parser -> result register -> rsp.
// Throughput: one byte per cycle; the input register drains into the parser
//   and result register whenever the result register is empty or being taken.
// Reset (synchronous, active high): parser returns to the header hunt with all
//   frame state cleared, registers reload their defaults, both stages empty.
// ----------------------------------------------------------------------------
// MSP v1 response decoder top level
// Input register, frame parser and result register on valid/ready channels.
// ----------------------------------------------------------------------------
module msp_v1_response_decoder_top (
   input  logic    clock,
   input  logic    reset,
   mrd_stream_if.sink   req_if,
   mrd_stream_if.source rsp_if,
   mrd_stream_if.sink   csr_if
);

   logic             in_valid_ff,  in_valid_in;
   mrd_pkg::req_type in_item_ff;
   logic             out_valid_ff, out_valid_in;
   mrd_pkg::rsp_type out_item_ff;

   logic             consume;
   logic             req_take;
   logic             res_valid;
   mrd_pkg::rsp_type res;
   mrd_pkg::cfg_type cfg;

   assign consume  = in_valid_ff & (~out_valid_ff | rsp_if.ready);
   assign req_take = req_if.valid & req_if.ready;

   assign req_if.ready = ~in_valid_ff | consume;
   assign csr_if.ready = 1'b1;

   mrd_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_beat  (csr_if.payload),
      .cfg      (cfg)
   );

   mrd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (consume),
      .item      (in_item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (consume) begin
         out_valid_in = res_valid;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold payloads until the next beat lands
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_if.payload;
      end
      if (consume && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_item_ff;

endmodule

@@ tb/tb_msp_v1_response_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP v1 response decoder testbench
// Feeds header, frame, abort and noise beats through the decoder, predicts
// every payload and frame end beat in step with the accepted input, and
// checks each result beat field by field under several register settings.
// ----------------------------------------------------------------------------
module tb_msp_v1_response_decoder_top;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_AFTER   = 350;
   localparam int unsigned HOLD_CYCLES  = 300;

   typedef enum logic [2:0] {
      SEEK_START   = 3'd0,
      SEEK_M       = 3'd1,
      SEEK_DIR     = 3'd2,
      TAKE_LENGTH  = 3'd3,
      TAKE_COMMAND = 3'd4,
      TAKE_BODY    = 3'd5
   } parse_state_type;

   logic clock = 1'b0;
   logic reset;

   mrd_stream_if #(.payload_type(mrd_pkg::req_type)) req_ch ();
   mrd_stream_if #(.payload_type(mrd_pkg::rsp_type)) rsp_ch ();
   mrd_stream_if #(.payload_type(mrd_pkg::csr_type)) csr_ch ();

   msp_v1_response_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   mrd_pkg::req_type rx_backlog[$];
   mrd_pkg::csr_type csr_backlog[$];
   mrd_pkg::rsp_type decoded_results[$];

   bit          idling_on = 1'b1;
   int unsigned rx_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned hold_left = 0;
   bit          hold_spent = 1'b0;
   int unsigned bytes_taken = 0;
   int unsigned queued_items = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // decoder shadow state and register copies
   parse_state_type dec_phase;
   logic [7:0]      dec_length;
   logic [7:0]      dec_command;
   logic [7:0]      dec_checksum;
   logic [7:0]      dec_count;
   logic [7:0]      cfg_expected_command;
   logic [7:0]      cfg_store_limit;

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   function automatic void clear_frame();
      dec_phase    = SEEK_START;
      dec_length   = '0;
      dec_command  = '0;
      dec_checksum = '0;
      dec_count    = '0;
   endfunction

   function automatic void decode_beat(mrd_pkg::req_type beat);
      mrd_pkg::rsp_type res;
      res = '0;
      if (beat.action == mrd_pkg::ACTION_ABORT) begin
         clear_frame();
         return;
      end
      unique case (dec_phase)
         SEEK_M:
            dec_phase = (beat.rx_byte == mrd_pkg::HDR_M) ? SEEK_DIR : SEEK_START;
         SEEK_DIR:
            dec_phase = (beat.rx_byte == mrd_pkg::HDR_DIR) ? TAKE_LENGTH : SEEK_START;
         TAKE_LENGTH: begin
            dec_length   = beat.rx_byte;
            dec_checksum = dec_checksum ^ beat.rx_byte;
            dec_phase    = TAKE_COMMAND;
         end
         TAKE_COMMAND: begin
            dec_command  = beat.rx_byte;
            dec_checksum = dec_checksum ^ beat.rx_byte;
            dec_phase    = TAKE_BODY;
         end
         TAKE_BODY: begin
            if (dec_count < dec_length) begin
               dec_checksum = dec_checksum ^ beat.rx_byte;
               if (dec_count < cfg_store_limit) begin
                  res.result_kind   = mrd_pkg::KIND_PAYLOAD;
                  res.payload_byte  = beat.rx_byte;
                  res.payload_index = dec_count;
                  decoded_results.push_back(res);
               end
               dec_count = dec_count + 8'd1;
            end else begin
               // command mismatch outranks a bad checksum
               res.result_kind = mrd_pkg::KIND_FRAME_END;
               if (dec_command != cfg_expected_command)
                  res.frame_status = mrd_pkg::STATUS_COMMAND;
               else if (dec_checksum != beat.rx_byte)
                  res.frame_status = mrd_pkg::STATUS_CHECKSUM;
               else
                  res.frame_status = mrd_pkg::STATUS_OK;
               res.frame_length = dec_length;
               decoded_results.push_back(res);
               clear_frame();
            end
         end
         default:
            dec_phase = (beat.rx_byte == mrd_pkg::HDR_START) ? SEEK_M : SEEK_START;
      endcase
   endfunction

   // input driver
   always @(posedge clock) begin : rx_driver
      logic             next_valid;
      mrd_pkg::req_type next_beat;
      next_valid = req_ch.valid;
      next_beat  = req_ch.payload;
      if (reset) begin
         next_valid = 1'b0;
         next_beat  = '0;
         rx_gap     = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) next_valid = 1'b0;
         if (!next_valid) begin
            if (rx_gap != 0) begin
               rx_gap--;
            end else if (rx_backlog.size() != 0) begin
               next_beat  = rx_backlog.pop_front();
               next_valid = 1'b1;
               if (idling_on && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 10);
            end
         end
      end
      req_ch.valid   <= next_valid;
      req_ch.payload <= next_beat;
   end

   // register write driver
   always @(posedge clock) begin : csr_driver
      logic             next_valid;
      mrd_pkg::csr_type next_beat;
      next_valid = csr_ch.valid;
      next_beat  = csr_ch.payload;
      if (reset) begin
         next_valid = 1'b0;
         next_beat  = '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) next_valid = 1'b0;
         if (!next_valid && csr_backlog.size() != 0) begin
            next_beat  = csr_backlog.pop_front();
            next_valid = 1'b1;
         end
      end
      csr_ch.valid   <= next_valid;
      csr_ch.payload <= next_beat;
   end

   // long receiver hold-off, once, while the sender keeps going
   always @(posedge clock) begin : rsp_long_hold
      if (reset) begin
         hold_left  <= 0;
         hold_spent <= 1'b0;
      end else if (!hold_spent && bytes_taken >= HOLD_AFTER) begin
         hold_left  <= HOLD_CYCLES;
         hold_spent <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // predict on accepted input, then check accepted results
   always @(posedge clock) begin : decoder_monitor
      mrd_pkg::rsp_type want;
      mrd_pkg::rsp_type got;
      logic             next_ready;
      if (reset) begin
         cfg_expected_command = mrd_pkg::EXPECTED_COMMAND_RESET;
         cfg_store_limit      = mrd_pkg::STORE_LIMIT_RESET;
         clear_frame();
         decoded_results.delete();
         rsp_stall   = 0;
         next_ready  = 1'b0;
         bytes_taken <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.payload.index == mrd_pkg::CSR_EXPECTED_COMMAND)
               cfg_expected_command = csr_ch.payload.data;
            else if (csr_ch.payload.index == mrd_pkg::CSR_STORE_LIMIT)
               cfg_store_limit = csr_ch.payload.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            decode_beat(req_ch.payload);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (decoded_results.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing pending", got));
            end else begin
               want = decoded_results.pop_front();
               if (got.result_kind !== want.result_kind)
                  report_mismatch($sformatf("result_kind got %0d want %0d",
                                            got.result_kind, want.result_kind));
               if (got.payload_byte !== want.payload_byte)
                  report_mismatch($sformatf("payload_byte got %h want %h",
                                            got.payload_byte, want.payload_byte));
               if (got.payload_index !== want.payload_index)
                  report_mismatch($sformatf("payload_index got %0d want %0d",
                                            got.payload_index, want.payload_index));
               if (got.frame_status !== want.frame_status)
                  report_mismatch($sformatf("frame_status got %0d want %0d",
                                            got.frame_status, want.frame_status));
               if (got.frame_length !== want.frame_length)
                  report_mismatch($sformatf("frame_length got %0d want %0d",
                                            got.frame_length, want.frame_length));
            end
         end
         if (rsp_stall != 0) rsp_stall--;
         else if (idling_on && $urandom_range(0, 9) == 0) rsp_stall = $urandom_range(1, 10);
         next_ready = (rsp_stall == 0) && (hold_left == 0);
      end
      rsp_ch.ready <= next_ready;
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic add_byte(logic [7:0] b);
      rx_backlog.push_back('{mrd_pkg::ACTION_BYTE, b});
      queued_items++;
   endtask

   task automatic add_abort();
      rx_backlog.push_back('{mrd_pkg::ACTION_ABORT, 8'($urandom)});
      queued_items++;
   endtask

   // header, length, command, payload, checksum; optionally cut by an abort
   task automatic add_frame(logic [7:0] cmd, int unsigned len, bit good_sum, bit cut_short);
      logic [7:0]  sum;
      logic [7:0]  b;
      int unsigned cut_at;
      sum = 8'(len) ^ cmd;
      add_byte(mrd_pkg::HDR_START);
      add_byte(mrd_pkg::HDR_M);
      add_byte(mrd_pkg::HDR_DIR);
      add_byte(8'(len));
      add_byte(cmd);
      cut_at = cut_short ? $urandom_range(0, len) : len + 1;
      for (int unsigned i = 0; i < len; i++) begin
         if (i == cut_at) begin
            add_abort();
            return;
         end
         b   = 8'($urandom);
         sum = sum ^ b;
         add_byte(b);
      end
      if (cut_at == len) begin
         add_abort();
         return;
      end
      add_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
   endtask

   task automatic random_traffic(int unsigned goal);
      int unsigned first;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  cmd;
      first = queued_items;
      while (queued_items - first < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            cmd = ($urandom_range(0, 4) == 0) ? 8'($urandom) : cfg_expected_command;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            add_frame(cmd, len, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 6);
         end else if (pick < 75) begin
            add_byte(mrd_pkg::HDR_START);
            if ($urandom_range(0, 1) == 1) add_byte(mrd_pkg::HDR_M);
            add_byte(8'($urandom));
         end else if (pick < 85) begin
            add_abort();
         end else begin
            // noise between frames; the hunt drops it
            repeat ($urandom_range(1, 4))
               rx_backlog.push_back('{mrd_pkg::ACTION_BYTE, 8'($urandom)});
         end
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (rx_backlog.size() != 0 || req_ch.valid || decoded_results.size() != 0)
         @(negedge clock);
      // let result-free beats still in the pipe settle
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_decoder_config(logic [7:0] cmd, logic [7:0] limit);
      csr_backlog.push_back('{mrd_pkg::CSR_EXPECTED_COMMAND, cmd});
      csr_backlog.push_back('{mrd_pkg::CSR_STORE_LIMIT, limit});
      @(negedge clock);
      while (csr_backlog.size() != 0 || csr_ch.valid) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, under reset register values
      // a second dollar sign while M is wanted drops back to the hunt
      add_byte(mrd_pkg::HDR_START);
      add_byte(mrd_pkg::HDR_START);
      add_byte(mrd_pkg::HDR_M);
      add_byte(mrd_pkg::HDR_DIR);
      // good frame, extreme payload bytes
      add_byte(mrd_pkg::HDR_START);
      add_byte(mrd_pkg::HDR_M);
      add_byte(mrd_pkg::HDR_DIR);
      add_byte(8'h02);
      add_byte(mrd_pkg::EXPECTED_COMMAND_RESET);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'h02 ^ mrd_pkg::EXPECTED_COMMAND_RESET ^ 8'hFF);
      // wrong command and bad checksum at once
      add_byte(mrd_pkg::HDR_START);
      add_byte(mrd_pkg::HDR_M);
      add_byte(mrd_pkg::HDR_DIR);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'h00);
      // zero length with a bad checksum
      add_byte(mrd_pkg::HDR_START);
      add_byte(mrd_pkg::HDR_M);
      add_byte(mrd_pkg::HDR_DIR);
      add_byte(8'h00);
      add_byte(mrd_pkg::EXPECTED_COMMAND_RESET);
      add_byte(8'h55);
      // abort in the middle of the header
      add_byte(mrd_pkg::HDR_START);
      add_byte(mrd_pkg::HDR_M);
      add_abort();
      wait_idle();

      set_decoder_config(8'd0, 8'd0);
      random_traffic(120);
      wait_idle();

      set_decoder_config(8'd255, 8'd255);
      add_frame(8'd255, 255, 1'b1, 1'b0);
      random_traffic(100);
      wait_idle();

      set_decoder_config(8'($urandom), 8'($urandom_range(1, 20)));
      random_traffic(180);
      wait_idle();

      idling_on = 1'b0;
      set_decoder_config(8'($urandom), 8'($urandom));
      random_traffic(120);
      wait_idle();

      if (mismatch_count == 0 && decoded_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
